/* hw/rtl/wmss_pkg.sv */
// shared types and constants for the weighted masked signature scan
// no dependencies; imported by the controller, datapath and top level
package wmss_pkg;

   localparam int MAX_PATTERNS      = 16;
   localparam int MAX_PATTERN_BYTES = 32;
   localparam int SLOT_W   = $clog2(MAX_PATTERNS);
   localparam int CNT_W    = $clog2(MAX_PATTERNS + 1);
   localparam int BPOS_W   = $clog2(MAX_PATTERN_BYTES);
   localparam int FILL_W   = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int LEN_W    = 6;
   localparam int SCORE_W  = 16;
   localparam int OFFSET_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_COUNT   = 1'd1;

   typedef enum logic [1:0] {
      FUNC_LOAD_BYTE   = 2'd0,
      FUNC_LOAD_HEADER = 2'd1,
      FUNC_REGION_BYTE = 2'd2,
      FUNC_NEW_SCAN    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      func_type           func;
      logic [SLOT_W-1:0]  slot;
      logic [BPOS_W-1:0]  byte_position;
      logic [7:0]         byte_value;
      logic [7:0]         byte_mask;
      logic [LEN_W-1:0]   pattern_length;
      logic [7:0]         pattern_weight;
      logic               last_in_region;
   } req_type;

   typedef struct packed {
      logic                detected;
      logic                match_valid;
      logic [OFFSET_W-1:0] match_offset;
      logic [SLOT_W-1:0]   match_slot;
      logic [SCORE_W-1:0]  total_score;
   } rsp_type;

   typedef struct packed {
      logic [7:0] mask;
      logic [7:0] value;
   } pat_byte_type;

   typedef struct packed {
      logic              load_byte;
      logic              load_header;
      logic              new_scan;
      logic              push_byte;
      logic              issue;
      logic [SLOT_W-1:0] issue_slot;
      logic              eval;
      logic              pos_done;
      logic              region_clear;
      logic              rsp_load;
      logic              rsp_detected;
   } cmd_type;

   typedef struct packed {
      logic              latched;
      logic [FILL_W-1:0] fill;
      logic [CNT_W-1:0]  active_count;
      logic              det_hit;
      logic              rsp_free;
   } status_type;

endpackage

/* hw/rtl/weighted_masked_signature_scan.sv */
// loads, new scan and region bytes that complete no start position leave the sequencer idle;
// a start position reads one slot row per cycle until every active slot is read or a detection ends it;
// a last byte flushes up to 32 positions, then the result is posted
// synchronous active-high reset clears scan state, threshold to 10, pattern count to 0;
// pattern store and window contents are not cleared
module weighted_masked_signature_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  wmss_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output wmss_pkg::rsp_type               rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [wmss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wmss_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import wmss_pkg::*;

   cmd_type    cmd;
   status_type status;

   wmss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .status      (status),
      .cmd         (cmd)
   );

   wmss_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/wmss_ctrl.sv */
// scan sequencer: steps slots per start position, flushes at region end
// depends on wmss_pkg; drives the datapath through cmd_type
module wmss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wmss_pkg::req_type   req_payload,
   input  wmss_pkg::status_type status,
   output wmss_pkg::cmd_type   cmd
);
   import wmss_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] sidx_ff, sidx_in;
   logic             pvld_ff, pvld_in;
   logic             flush_ff, flush_in;
   logic             det_ff, det_in;

   logic accept, det_now, issue, pos_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign det_now   = pvld_ff & status.det_hit;
   assign issue     = (state_ff == ST_SCAN) & ~det_now & (sidx_ff < status.active_count);
   assign pos_end   = (state_ff == ST_SCAN) & ~det_now & ~pvld_ff
                      & (sidx_ff >= status.active_count);

   // next state
   always_comb begin
      state_in = state_ff;
      sidx_in  = sidx_ff;
      pvld_in  = 1'b0;
      flush_in = flush_ff;
      det_in   = det_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.func == FUNC_REGION_BYTE && !status.latched) begin
               if (req_payload.last_in_region ||
                   status.fill == FILL_W'(MAX_PATTERN_BYTES - 1)) begin
                  state_in = ST_SCAN;
                  sidx_in  = '0;
                  flush_in = req_payload.last_in_region;
               end
            end
         end
         ST_SCAN: begin
            pvld_in = issue;
            if (issue) sidx_in = sidx_ff + 1'b1;
            if (det_now) begin
               state_in = ST_EMIT;
               det_in   = 1'b1;
            end else if (pos_end) begin
               sidx_in = '0;
               if (!flush_ff) begin
                  state_in = ST_IDLE;
               end else if (status.fill == FILL_W'(1)) begin
                  state_in = ST_EMIT;
                  det_in   = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd              = '0;
      cmd.load_byte    = accept & (req_payload.func == FUNC_LOAD_BYTE);
      cmd.load_header  = accept & (req_payload.func == FUNC_LOAD_HEADER);
      cmd.new_scan     = accept & (req_payload.func == FUNC_NEW_SCAN);
      cmd.push_byte    = accept & (req_payload.func == FUNC_REGION_BYTE) & ~status.latched;
      cmd.issue        = issue;
      cmd.issue_slot   = sidx_ff[SLOT_W-1:0];
      cmd.eval         = (state_ff == ST_SCAN) & pvld_ff;
      cmd.pos_done     = pos_end;
      cmd.region_clear = pos_end & flush_ff & (status.fill == FILL_W'(1));
      cmd.rsp_load     = (state_ff == ST_EMIT) & status.rsp_free;
      cmd.rsp_detected = det_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sidx_ff  <= '0;
         pvld_ff  <= 1'b0;
         flush_ff <= 1'b0;
         det_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sidx_ff  <= sidx_in;
         pvld_ff  <= pvld_in;
         flush_ff <= flush_in;
         det_ff   <= det_in;
      end
   end

endmodule

/* hw/rtl/wmss_dp.sv */
// datapath: pattern store, byte window, match compare, score and result register
// depends on wmss_pkg; commanded by wmss_ctrl
module wmss_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  wmss_pkg::req_type        req_payload,
   input  logic                     csr_wr_en,
   input  logic [wmss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wmss_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  wmss_pkg::cmd_type        cmd,
   output wmss_pkg::status_type     status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output wmss_pkg::rsp_type        rsp_payload
);
   import wmss_pkg::*;

   // pattern store: one row per slot, byte-wide writes, registered row read
   pat_byte_type [MAX_PATTERN_BYTES-1:0] pat_mem [MAX_PATTERNS];
   logic [LEN_W-1:0] len_mem [MAX_PATTERNS];
   logic [7:0]       wt_mem  [MAX_PATTERNS];

   pat_byte_type [MAX_PATTERN_BYTES-1:0] row_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [7:0]        wt_ff;
   logic [SLOT_W-1:0] eslot_ff;

   // window: entry 0 is the first byte of the oldest pending start position
   logic [7:0] win_ff [MAX_PATTERN_BYTES];
   logic [FILL_W-1:0]   fill_ff;
   logic [OFFSET_W-1:0] count_ff;
   logic [SCORE_W-1:0]  score_ff;
   logic                latched_ff;
   logic                mvalid_ff;
   logic [OFFSET_W-1:0] moffset_ff;
   logic [SLOT_W-1:0]   mslot_ff;

   logic [SCORE_W-1:0]  thr_ff;
   logic [CNT_W-1:0]    pcount_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                 bytes_ok, hit;
   logic [SCORE_W:0]     sum;
   logic [SCORE_W-1:0]   score_in;

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         pat_mem[req_payload.slot][req_payload.byte_position] <=
            '{mask: req_payload.byte_mask, value: req_payload.byte_value};
      end
      if (cmd.load_header) begin
         len_mem[req_payload.slot] <= req_payload.pattern_length;
         wt_mem[req_payload.slot]  <= req_payload.pattern_weight;
      end
      if (cmd.issue) begin
         row_ff   <= pat_mem[cmd.issue_slot];
         len_ff   <= len_mem[cmd.issue_slot];
         wt_ff    <= wt_mem[cmd.issue_slot];
         eslot_ff <= cmd.issue_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_byte) begin
         win_ff[fill_ff[BPOS_W-1:0]] <= req_payload.byte_value;
      end else if (cmd.pos_done) begin
         for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) win_ff[i] <= win_ff[i+1];
      end
   end

   always_comb begin
      bytes_ok = 1'b1;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         if ((LEN_W'(k) < len_ff) &&
             ((win_ff[k] & row_ff[k].mask) != (row_ff[k].value & row_ff[k].mask)))
            bytes_ok = 1'b0;
      end
   end

   assign hit      = bytes_ok && (len_ff <= LEN_W'(MAX_PATTERN_BYTES))
                     && ({1'b0, len_ff} <= (LEN_W+1)'(fill_ff));
   assign sum      = {1'b0, score_ff} + {{(SCORE_W-7){1'b0}}, wt_ff};
   assign score_in = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         count_ff   <= '0;
         score_ff   <= '0;
         latched_ff <= 1'b0;
         mvalid_ff  <= 1'b0;
         moffset_ff <= '0;
         mslot_ff   <= '0;
      end else if (cmd.new_scan) begin
         fill_ff    <= '0;
         count_ff   <= '0;
         score_ff   <= '0;
         latched_ff <= 1'b0;
         mvalid_ff  <= 1'b0;
         moffset_ff <= '0;
         mslot_ff   <= '0;
      end else begin
         if (cmd.push_byte) begin
            fill_ff  <= fill_ff + 1'b1;
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pos_done) begin
            fill_ff <= fill_ff - 1'b1;
         end
         if (cmd.region_clear) count_ff <= '0;
         if (cmd.eval && hit) begin
            score_ff   <= score_in;
            mvalid_ff  <= 1'b1;
            moffset_ff <= count_ff - OFFSET_W'(fill_ff);
            mslot_ff   <= eslot_ff;
            if (score_in >= thr_ff) latched_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= SCORE_W'(10);
         pcount_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCORE_THRESHOLD: thr_ff    <= csr_wr_data[SCORE_W-1:0];
            CSR_PATTERN_COUNT:   pcount_ff <= csr_wr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= '{detected: cmd.rsp_detected, match_valid: mvalid_ff,
                     match_offset: moffset_ff, match_slot: mslot_ff,
                     total_score: score_ff};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.latched      = latched_ff;
   assign status.fill         = fill_ff;
   assign status.active_count = (pcount_ff > CNT_W'(MAX_PATTERNS)) ?
                                CNT_W'(MAX_PATTERNS) : pcount_ff;
   assign status.det_hit      = hit & (score_in >= thr_ff);
   assign status.rsp_free     = ~rsp_valid_ff | rsp_ready;

endmodule
